// File: rtl/core/sitda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int unsigned ValueWidth = 64;
	localparam int unsigned NumDigits  = 20;
	localparam int unsigned BcdWidth   = 4 * NumDigits;
	// Bits of the magnitude consumed per double-dabble pipeline stage
	localparam int unsigned BitsPerStage = 8;
	localparam int unsigned NumStages    = ValueWidth / BitsPerStage;

	localparam logic [1:0] SignNone  = 2'd0;
	localparam logic [1:0] SignBlank = 2'd1;
	localparam logic [1:0] SignPlus  = 2'd2;

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChBlank = 8'h20;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0]         sign_mode;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} out_beat_t;

	// Converted number handed from the converter to the serialiser
	typedef struct packed {
		logic [BcdWidth-1:0] bcd;
		logic                negative;
		logic [1:0]          sign_mode;
	} conv_t;

endpackage

// File: rtl/core/sitda_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_conv
// Pipelined double-dabble: magnitude to BCD, eight bits per stage.
// ----------------------------------------------------------------------------
module sitda_conv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  sitda_pkg::in_beat_t data,
	output logic                conv_valid,
	input  logic                conv_stall,
	output sitda_pkg::conv_t    conv_data
);

	localparam int unsigned NS = sitda_pkg::NumStages;
	localparam int unsigned BW = sitda_pkg::BcdWidth;
	localparam int unsigned VW = sitda_pkg::ValueWidth;
	localparam int unsigned BP = sitda_pkg::BitsPerStage;

	logic          vld_s  [NS+1];
	logic [BW-1:0] bcd_s  [NS+1];
	logic [VW-1:0] mag_s  [NS+1];
	logic          neg_s  [NS+1];
	logic [1:0]    mode_s [NS+1];
	logic          adv;

	// Whole pipe moves as one; it halts only when the tail is held
	assign adv   = !(vld_s[NS] && conv_stall);
	assign stall = !adv;

	// Stage zero: take magnitude without overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid) begin
			neg_s[0]  <= data.value[VW-1];
			mag_s[0]  <= data.value[VW-1] ? (VW'(0) - VW'(data.value)) : VW'(data.value);
			mode_s[0] <= data.sign_mode;
			bcd_s[0]  <= '0;
		end
	end

	// Shift-and-add-3 stages
	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [BW-1:0] b_n;
		logic [VW-1:0] m_n;

		always_comb begin
			b_n = bcd_s[g];
			m_n = mag_s[g];
			for (int i = 0; i < BP; i++) begin
				for (int d = 0; d < sitda_pkg::NumDigits; d++) begin
					if (b_n[4*d +: 4] >= 4'd5) begin
						b_n[4*d +: 4] = b_n[4*d +: 4] + 4'd3;
					end
				end
				b_n = {b_n[BW-2:0], m_n[VW-1]};
				m_n = {m_n[VW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv && vld_s[g]) begin
				bcd_s[g+1]  <= b_n;
				mag_s[g+1]  <= m_n;
				neg_s[g+1]  <= neg_s[g];
				mode_s[g+1] <= mode_s[g];
			end
		end
	end

	assign conv_valid          = vld_s[NS];
	assign conv_data.bcd       = bcd_s[NS];
	assign conv_data.negative  = neg_s[NS];
	assign conv_data.sign_mode = mode_s[NS];

`ifndef SYNTHESIS
	// A held result stays put while the serialiser is busy
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		conv_valid && conv_stall |=> conv_valid && $stable(conv_data))
		else $error("converter output changed while held");
	// Input stall only when the tail is held
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> conv_valid && conv_stall)
		else $error("spurious input stall");
	// The top and bottom BCD digits are decimal digits
	a_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		conv_valid |-> conv_data.bcd[79:76] <= 4'd9 && conv_data.bcd[3:0] <= 4'd9)
		else $error("bad BCD digit");
`endif

endmodule

// File: rtl/core/signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// Path: an accepted input beat reaches its first output beat through the input
// register, eight converter stages, a load step and the output register.
// Throughput: the serialiser loads a number, then sends one character a cycle
// while the output is not stalled, and takes the next number only after the last
// character; the converter can take a beat a cycle unless its tail is held.
// Reset: arst_n clears all valid bits and the serialiser control; no data register.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed 64-bit integer to decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sitda_pkg::in_beat_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sitda_pkg::out_beat_t out_data
);

	logic             cv;
	logic             cs;
	sitda_pkg::conv_t cd;

	sitda_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (in_valid),
		.stall      (in_stall),
		.data       (in_data),
		.conv_valid (cv),
		.conv_stall (cs),
		.conv_data  (cd)
	);

	// Serialiser state
	logic        busy_q;
	logic [79:0] bcd_q;
	logic [4:0]  left_q;   // digits still to send
	logic        sgn_q;    // sign character pending
	logic [7:0]  sch_q;
	logic        ov_q;
	logic [7:0]  och_q;
	logic        olast_q;

	// Leading digit count
	logic [4:0] nd;
	always_comb begin
		nd = 5'd1;
		for (int d = 1; d < 20; d++) begin
			if (cd.bcd[4*d +: 4] != 4'd0) begin
				nd = 5'(d + 1);
			end
		end
	end

	logic [7:0] sc;
	logic       hs;
	always_comb begin
		hs = 1'b1;
		sc = sitda_pkg::ChMinus;
		if (!cd.negative) begin
			if (cd.sign_mode[1]) begin
				sc = sitda_pkg::ChPlus;
			end else if (cd.sign_mode[0]) begin
				sc = sitda_pkg::ChBlank;
			end else begin
				hs = 1'b0;
			end
		end
	end

	logic ofree;
	assign ofree = !ov_q || !out_stall;
	assign cs    = busy_q;

	// Load a number, then send sign and digits most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			left_q <= '0;
			sgn_q  <= 1'b0;
		end else begin
			if (!busy_q) begin
				if (ofree) begin
					ov_q <= 1'b0;
				end
				if (cv) begin
					busy_q <= 1'b1;
					sgn_q  <= hs;
					left_q <= nd;
				end
			end else if (ofree) begin
				ov_q <= 1'b1;
				if (sgn_q) begin
					sgn_q <= 1'b0;
				end else begin
					left_q <= left_q - 5'd1;
					if (left_q == 5'd1) begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && cv) begin
			bcd_q <= cd.bcd;
			sch_q <= sc;
		end else if (busy_q && ofree) begin
			if (sgn_q) begin
				och_q   <= sch_q;
				olast_q <= 1'b0;
			end else begin
				och_q   <= sitda_pkg::ChZero | {4'd0, bcd_q[4*(left_q - 5'd1) +: 4]};
				olast_q <= (left_q == 5'd1);
			end
		end
	end

	assign out_valid          = ov_q;
	assign out_data.character = och_q;
	assign out_data.last      = olast_q;

`ifndef SYNTHESIS
	// Held output beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");
	// Serialiser never busy with no digits left
	a_left: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> left_q != 5'd0)
		else $error("busy with no digits");
	// Last beat ends the number
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && ofree && !sgn_q && left_q == 5'd1 |=> !busy_q)
		else $error("serialiser overran");
`endif

endmodule
